// ===== hw/rtl/jas_pkg.sv =====
// ----------------------------------------------------------------------------
// jas_pkg
// Shared types and constants of the JPEG application segment stripper.
// ----------------------------------------------------------------------------
package jas_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned JAS_QUEUE_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_MARKER  = 2'd1;

  localparam logic [BYTE_W-1:0] FIRST_MARKER_RST = 8'hE0;
  localparam logic [BYTE_W-1:0] LAST_MARKER_RST  = 8'hEF;

  localparam logic [BYTE_W-1:0] MARKER_PREFIX = 8'hFF;
  localparam logic [BYTE_W-1:0] SOI_CODE      = 8'hD8;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_present;
    logic              end_of_image;
    logic              rejected;
  } result_t;

  // all results caused by one input byte
  typedef struct packed {
    result_t res0;
    logic    has_second;
    result_t res1;
  } entry_t;

endpackage

// ===== hw/rtl/jas_byte_if.sv =====
// ----------------------------------------------------------------------------
// jas_byte_if
// Input byte channel: raw file bytes with an end-of-file flag.
// ----------------------------------------------------------------------------
interface jas_byte_if;
  logic                     valid;
  logic                     ready;
  logic [jas_pkg::BYTE_W-1:0] data_byte;
  logic                     end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

// ===== hw/rtl/jas_res_if.sv =====
// ----------------------------------------------------------------------------
// jas_res_if
// Result channel: stripped image bytes and end markers.
// ----------------------------------------------------------------------------
interface jas_res_if;
  logic                     valid;
  logic                     ready;
  logic [jas_pkg::BYTE_W-1:0] out_byte;
  logic                     byte_present;
  logic                     end_of_image;
  logic                     rejected;

  modport source (output valid, output out_byte, output byte_present,
                  output end_of_image, output rejected, input ready);
  modport sink   (input valid, input out_byte, input byte_present,
                  input end_of_image, input rejected, output ready);
endinterface

// ===== hw/rtl/jas_cfg_if.sv =====
// ----------------------------------------------------------------------------
// jas_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface jas_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [jas_pkg::CFG_IDX_W-1:0]  index;
  logic [jas_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/jpeg_app_segment_stripper.sv =====
// ----------------------------------------------------------------------------
// jpeg_app_segment_stripper
// Removes application segments with markers in a set range from a JPEG file.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one file byte per transaction, end_of_file set on the last byte.
//   out_o  : stripped bytes; a file ends on a result with end_of_image set,
//            which is a bare end marker (byte_present 0) when the last byte
//            produced no data, with rejected set if FF D8 was missing.
//   cfg_i  : index 0 first stripped marker code, index 1 last one; write
//            only while idle. Always ready.
// Throughput: one input byte per cycle while the queue has room, one result
//   per cycle while out_o is ready. A byte that yields two results (start
//   marker, a kept marker pair) occupies one queue entry and leaves it as
//   two results; the entry queue absorbs that.
// Reset: parser returns to expecting FF D8, the queue empties and the range
//   returns to E0..EF. After each final byte the parser restarts by itself.
// Stall: results wait in the output register and queue; in_i.ready drops
//   only when the queue is full.
// ----------------------------------------------------------------------------
module jpeg_app_segment_stripper #(
  parameter int unsigned QueueDepth = jas_pkg::JAS_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jas_byte_if.sink  in_i,
  jas_cfg_if.sink   cfg_i,
  jas_res_if.source out_o
);
  import jas_pkg::*;

  logic   push_valid, push_ready;
  entry_t push_data;
  logic   q_valid, q_pop;
  entry_t q_data;

  jas_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  jas_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  jas_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_data_i (q_data),
    .q_pop_o  (q_pop),
    .out_o    (out_o)
  );
endmodule

// ===== hw/rtl/jas_front.sv =====
// ----------------------------------------------------------------------------
// jas_front
// Parses the byte stream, holds the marker range registers and pushes the
// results of each byte into the queue as one entry.
// ----------------------------------------------------------------------------
module jas_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  jas_byte_if.sink          in_i,
  jas_cfg_if.sink           cfg_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output jas_pkg::entry_t   push_data_o
);
  import jas_pkg::*;

  localparam logic [3:0] PH_SOI_FIRST  = 4'd0;
  localparam logic [3:0] PH_SOI_SECOND = 4'd1;
  localparam logic [3:0] PH_MARK_HIGH  = 4'd2;
  localparam logic [3:0] PH_MARK_LOW   = 4'd3;
  localparam logic [3:0] PH_LEN_HIGH   = 4'd4;
  localparam logic [3:0] PH_LEN_LOW    = 4'd5;
  localparam logic [3:0] PH_BODY       = 4'd6;
  localparam logic [3:0] PH_PASS       = 4'd7;
  localparam logic [3:0] PH_REJECT     = 4'd8;

  logic [3:0]        phase_q, phase_d;
  logic [BYTE_W-1:0] held_q, held_d;
  logic [LEN_W-1:0]  skip_q, skip_d;
  logic              bad_q, bad_d;
  logic [BYTE_W-1:0] first_q, last_q;

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic              eof;
  logic [1:0]        n;
  result_t           r0, r1;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  skip_dec;
  logic              rej;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = push_ready_i;
  assign accept      = in_i.valid && push_ready_i;
  assign b           = in_i.data_byte;
  assign eof         = in_i.end_of_file;
  assign len         = {skip_q[LEN_W-1:BYTE_W], b};
  assign skip_dec    = (skip_q != '0) ? skip_q - LEN_W'(1) : skip_q;

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    skip_d  = skip_q;
    bad_d   = bad_q;
    n       = 2'd0;
    r0      = '{out_byte: b, byte_present: 1'b1, end_of_image: 1'b0, rejected: 1'b0};
    r1      = '{out_byte: b, byte_present: 1'b1, end_of_image: 1'b0, rejected: 1'b0};
    unique case (phase_q)
      PH_SOI_FIRST: begin
        if (b == MARKER_PREFIX) begin
          phase_d = PH_SOI_SECOND;
        end else begin
          bad_d   = 1'b1;
          phase_d = PH_REJECT;
        end
      end
      PH_SOI_SECOND: begin
        if (b == SOI_CODE) begin
          r0.out_byte = MARKER_PREFIX;
          r1.out_byte = SOI_CODE;
          n           = 2'd2;
          phase_d     = PH_MARK_HIGH;
        end else begin
          bad_d   = 1'b1;
          phase_d = PH_REJECT;
        end
      end
      PH_MARK_HIGH: begin
        held_d  = b;
        phase_d = PH_MARK_LOW;
        // a final byte cannot open a segment
        if (eof) n = 2'd1;
      end
      PH_MARK_LOW: begin
        if (held_q == MARKER_PREFIX && b >= first_q && b <= last_q) begin
          phase_d = PH_LEN_HIGH;
        end else begin
          r0.out_byte = held_q;
          n           = 2'd2;
          phase_d     = PH_PASS;
        end
      end
      PH_LEN_HIGH: begin
        skip_d  = {b, {BYTE_W{1'b0}}};
        phase_d = PH_LEN_LOW;
      end
      PH_LEN_LOW: begin
        if (len <= LEN_W'(2)) begin
          skip_d  = '0;
          phase_d = PH_MARK_HIGH;
        end else begin
          skip_d  = len - LEN_W'(2);
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        skip_d = skip_dec;
        if (skip_dec == '0) phase_d = PH_MARK_HIGH;
      end
      PH_PASS: begin
        n = 2'd1;
      end
      default: begin
        phase_d = PH_REJECT;
      end
    endcase

    rej = bad_d || phase_d == PH_SOI_SECOND || phase_d == PH_SOI_FIRST ||
          phase_d == PH_REJECT;

    if (eof) begin
      unique case (n)
        2'd0: begin
          r0 = '{out_byte: '0, byte_present: 1'b0, end_of_image: 1'b1, rejected: rej};
          n  = 2'd1;
        end
        2'd1:    r0.end_of_image = 1'b1;
        default: r1.end_of_image = 1'b1;
      endcase
      phase_d = PH_SOI_FIRST;
      held_d  = '0;
      skip_d  = '0;
      bad_d   = 1'b0;
    end
  end

  assign push_valid_o           = accept && (n != 2'd0);
  assign push_data_o.res0       = r0;
  assign push_data_o.has_second = (n == 2'd2);
  assign push_data_o.res1       = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SOI_FIRST;
      held_q  <= '0;
      skip_q  <= '0;
      bad_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      skip_q  <= skip_d;
      bad_q   <= bad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= FIRST_MARKER_RST;
      last_q  <= LAST_MARKER_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_FIRST_MARKER) first_q <= cfg_i.data;
      if (cfg_i.index == CFG_LAST_MARKER)  last_q  <= cfg_i.data;
    end
  end

`ifndef NO_ASSERTIONS
  // the final byte of a file always leaves the parser at the start marker
  a_eof_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && eof |=> phase_q == PH_SOI_FIRST && !bad_q)
    else $error("parser not restarted after end of file");

  // only the last result of a byte may carry the end flag
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o && push_data_o.has_second |-> !push_data_o.res0.end_of_image)
    else $error("end flag on a non-final result");
`endif
endmodule

// ===== hw/rtl/jas_queue.sv =====
// ----------------------------------------------------------------------------
// jas_queue
// Small FIFO of result entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module jas_queue #(
  parameter int unsigned Depth = jas_pkg::JAS_QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  jas_pkg::entry_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output jas_pkg::entry_t pop_data_o
);
  import jas_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push && !pop)      count_q <= count_q + CntW'(1);
      else if (pop && !push) count_q <= count_q - CntW'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count out of range");
`endif
endmodule

// ===== hw/rtl/jas_back.sv =====
// ----------------------------------------------------------------------------
// jas_back
// Output stage: unpacks queue entries into single results and holds each
// in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module jas_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  jas_pkg::entry_t q_data_i,
  output logic            q_pop_o,
  jas_res_if.source       out_o
);
  import jas_pkg::*;

  logic    out_valid_q;
  result_t out_data_q;
  logic    sel_q;       // second result of the head entry is next
  logic    load;
  logic    last_of_entry;

  assign load          = q_valid_i && (!out_valid_q || out_o.ready);
  assign last_of_entry = sel_q || !q_data_i.has_second;
  assign q_pop_o       = load && last_of_entry;

  always_ff @(posedge clk_i) begin
    if (load) out_data_q <= sel_q ? q_data_i.res1 : q_data_i.res0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      if (load)              out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
      if (load)              sel_q <= !last_of_entry;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_data_q.out_byte;
  assign out_o.byte_present = out_data_q.byte_present;
  assign out_o.end_of_image = out_data_q.end_of_image;
  assign out_o.rejected     = out_data_q.rejected;

`ifndef NO_ASSERTIONS
  // halfway through an entry, that entry stays at the head
  a_sel_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> q_valid_i && q_data_i.has_second)
    else $error("second result selected without a paired entry");
`endif
endmodule
